/* rtl/tcrr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the timed command record/replay block.
// Depends on nothing; every other rtl file refers to it by scoped names.
package tcrr_pkg;

    localparam int STORE_DEPTH_DEF  = 1024;
    localparam int MAX_PER_TICK_DEF = 64;

    localparam int TDATA_W = 144;

    // input command codes, carried on s_tuser
    typedef enum logic [2:0] {
        CMD_START_REC  = 3'd0,
        CMD_STOP       = 3'd1,
        CMD_START_PLAY = 3'd2,
        CMD_START_AUTO = 3'd3,
        CMD_RECORD     = 3'd4,
        CMD_TICK       = 3'd5,
        CMD_AUTO_TICK  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RECORD = 2'd1,
        MODE_PLAY   = 2'd2,
        MODE_AUTO   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_REPLAY   = 2'd1,
        KIND_FINISHED = 2'd2,
        KIND_DROPPED  = 2'd3
    } kind_t;

    // one stored command
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  func_id;
        logic [63:0] value_a;
        logic [63:0] value_b;
        logic [1:0]  gate_position;
    } rec_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  func_id;
        logic [63:0] value_a;
        logic [63:0] value_b;
        logic [1:0]  gate_position;
        mode_t       recorder_state;
        logic        last;
    } result_t;

endpackage

/* rtl/tcrr_store.sv */
`timescale 1ns / 1ps
// Record memory: one write port, one read port, read data registered.
// Depends on tcrr_pkg for the record layout.
module tcrr_store #(
    parameter int STORE_DEPTH = tcrr_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  tcrr_pkg::rec_t       wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output tcrr_pkg::rec_t       rd_data
);

    tcrr_pkg::rec_t mem [STORE_DEPTH];
    tcrr_pkg::rec_t rd_data_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tcrr_outreg.sv */
`timescale 1ns / 1ps
// Output register of the result stream; frees the control side from m_tready.
// Depends on tcrr_pkg for the result layout.
module tcrr_outreg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tcrr_pkg::result_t     din,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output tcrr_pkg::result_t     dout
);

    logic              valid_reg;
    logic              valid_next;
    tcrr_pkg::result_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = push || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= din;
        end
    end

    assign m_tvalid = valid_reg;
    assign dout     = data_reg;

endmodule

/* rtl/tcrr_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: decodes commands, writes records, walks the replay burst.
// Depends on tcrr_pkg; drives tcrr_store and tcrr_outreg.
module tcrr_ctrl #(
    parameter int STORE_DEPTH  = tcrr_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PER_TICK = tcrr_pkg::MAX_PER_TICK_DEF,
    parameter int AW           = $clog2(STORE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcrr_pkg::cmd_t        cmd,
    input  logic [7:0]            func_id,
    input  logic [63:0]           value_a,
    input  logic [63:0]           value_b,
    input  logic [1:0]            gate_position,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output tcrr_pkg::rec_t        wr_data,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  tcrr_pkg::rec_t        rd_data,
    input  logic                  out_free,
    output logic                  out_push,
    output tcrr_pkg::result_t     out_data
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int NW = $clog2(MAX_PER_TICK + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    tcrr_pkg::mode_t     mode_reg, mode_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [31:0]         tick_reg, tick_next;
    logic [NW-1:0]       same_reg, same_next;
    logic [NW-1:0]       n_reg, n_next;
    tcrr_pkg::result_t   pend_reg, pend_next;
    logic                accept;
    logic                match;
    logic                more;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign match    = (rd_data.stamp == tick_reg);
    assign more     = ((ptr_reg + CW'(1)) < count_reg) && ((n_reg + NW'(1)) < NW'(MAX_PER_TICK));

    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = '{stamp: tick_reg, func_id: func_id, value_a: value_a,
                       value_b: value_b, gate_position: gate_position};

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        tick_next  = tick_reg;
        same_next  = same_reg;
        n_next     = n_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[AW-1:0];
        out_push   = 1'b0;
        out_data   = pend_reg;
        out_data.recorder_state = mode_reg;
        out_data.last           = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '{kind: tcrr_pkg::KIND_ACK, recorder_state: tcrr_pkg::MODE_IDLE,
                                  default: '0};
                    state_next = ST_FLUSH;
                    unique case (cmd)
                        tcrr_pkg::CMD_START_REC:
                        begin
                            count_next = '0;
                            tick_next  = '0;
                            same_next  = '0;
                            mode_next  = tcrr_pkg::MODE_RECORD;
                        end
                        tcrr_pkg::CMD_STOP:
                        begin
                            mode_next = tcrr_pkg::MODE_IDLE;
                        end
                        tcrr_pkg::CMD_START_PLAY, tcrr_pkg::CMD_START_AUTO:
                        begin
                            tick_next = '0;
                            ptr_next  = '0;
                            mode_next = (cmd == tcrr_pkg::CMD_START_PLAY) ?
                                        tcrr_pkg::MODE_PLAY : tcrr_pkg::MODE_AUTO;
                        end
                        tcrr_pkg::CMD_RECORD:
                        begin
                            if (mode_reg == tcrr_pkg::MODE_RECORD)
                            begin
                                if ((count_reg >= CW'(STORE_DEPTH)) ||
                                    (same_reg >= NW'(MAX_PER_TICK)))
                                begin
                                    pend_next.kind          = tcrr_pkg::KIND_DROPPED;
                                    pend_next.func_id       = func_id;
                                    pend_next.value_a       = value_a;
                                    pend_next.value_b       = value_b;
                                    pend_next.gate_position = gate_position;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                    same_next  = same_reg + NW'(1);
                                end
                            end
                        end
                        tcrr_pkg::CMD_TICK, tcrr_pkg::CMD_AUTO_TICK:
                        begin
                            if ((cmd == tcrr_pkg::CMD_TICK) != (mode_reg == tcrr_pkg::MODE_AUTO))
                            begin
                                tick_next = tick_reg + 32'd1;
                                same_next = '0;
                                if (mode_reg == tcrr_pkg::MODE_PLAY ||
                                    mode_reg == tcrr_pkg::MODE_AUTO)
                                begin
                                    if (ptr_reg >= count_reg)
                                    begin
                                        mode_next      = tcrr_pkg::MODE_IDLE;
                                        pend_next.kind = tcrr_pkg::KIND_FINISHED;
                                    end
                                    else
                                    begin
                                        // fetch the record under the pointer
                                        rd_en      = 1'b1;
                                        n_next     = '0;
                                        state_next = ST_CHECK;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (match)
                begin
                    // hold the new record until the previous one can leave
                    if (n_reg == '0 || out_free)
                    begin
                        out_push       = (n_reg != '0);
                        out_data.last  = 1'b0;
                        pend_next      = '{kind: tcrr_pkg::KIND_REPLAY,
                                           func_id: rd_data.func_id,
                                           value_a: rd_data.value_a,
                                           value_b: rd_data.value_b,
                                           gate_position: rd_data.gate_position,
                                           recorder_state: tcrr_pkg::MODE_IDLE,
                                           last: 1'b0};
                        n_next         = n_reg + NW'(1);
                        ptr_next       = ptr_reg + CW'(1);
                        if (more)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = ptr_next[AW-1:0];
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
                else
                begin
                    if (n_reg == '0)
                    begin
                        pend_next = '{kind: tcrr_pkg::KIND_ACK,
                                      recorder_state: tcrr_pkg::MODE_IDLE, default: '0};
                    end
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= tcrr_pkg::MODE_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            tick_reg  <= '0;
            same_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            tick_reg  <= tick_next;
            same_reg  <= same_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* rtl/timed_command_record_replay.sv */
`timescale 1ns / 1ps
// Top level of the timed command record/replay block.
// Depends on tcrr_pkg, tcrr_store, tcrr_outreg and tcrr_ctrl.
//
// Usage:
//   s_* carries one command word: s_tuser is the command code, s_tdata the
//   command fields. m_* returns result words: m_tuser is the result kind,
//   m_tdata the record fields and the recorder mode, m_tlast marks the final
//   result of a command. Every command yields at least one result.
//   A command other than a replaying tick leaves its result in a pending
//   register that moves to the output register once that is free; a
//   replaying tick reads one record per cycle while the output register
//   takes them, the burst ending at store end, per-tick limit or a later stamp.
//   One command at a time: the next is accepted only after the last result
//   of the previous one enters the output register.
//   Reset clears the mode to idle and empties the store at once (no sweep);
//   memory contents are left as they are.
//   When the receiver stalls, the output register holds its word and the
//   replay walk waits with the next record fetched; no word is lost.
module timed_command_record_replay #(
    parameter int STORE_DEPTH  = tcrr_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PER_TICK = tcrr_pkg::MAX_PER_TICK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func_id[7:0], value_a[71:8], value_b[135:72], gate_position[137:136]
    input  logic [tcrr_pkg::TDATA_W-1:0]  s_tdata,
    // command code[2:0]
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_func_id[7:0], out_value_a[71:8], out_value_b[135:72],
    // out_gate_position[137:136], recorder_state[139:138]
    output logic [tcrr_pkg::TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    tcrr_pkg::rec_t    wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    tcrr_pkg::rec_t    rd_data;
    logic              out_free;
    logic              out_push;
    tcrr_pkg::result_t out_data;
    tcrr_pkg::result_t res;

    tcrr_ctrl #(
        .STORE_DEPTH  (STORE_DEPTH),
        .MAX_PER_TICK (MAX_PER_TICK),
        .AW           (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .cmd           (tcrr_pkg::cmd_t'(s_tuser)),
        .func_id       (s_tdata[7:0]),
        .value_a       (s_tdata[71:8]),
        .value_b       (s_tdata[135:72]),
        .gate_position (s_tdata[137:136]),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_free      (out_free),
        .out_push      (out_push),
        .out_data      (out_data)
    );

    tcrr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcrr_outreg u_outreg (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .din      (out_data),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (res)
    );

    assign m_tdata = {4'd0, res.recorder_state, res.gate_position,
                      res.value_b, res.value_a, res.func_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
